// ===== rtl/mmeq_pkg.sv =====
// ----------------------------------------------------------------------------
// mmeq_pkg
// Shared types and constants for the matrix multiply element query block:
// operation codes, sequencer states, field widths and pipeline tags.
// ----------------------------------------------------------------------------
package mmeq_pkg;

	// default matrix dimensions
	localparam int DEF_ROWS_A = 16;
	localparam int DEF_INNER  = 16;
	localparam int DEF_COLS_B = 16;

	// fixed field widths
	localparam int IDX_W  = 4;   // row and col ports
	localparam int VAL_W  = 16;  // Q1.15 entry
	localparam int PROD_W = 32;  // Q2.30 product
	localparam int OUT_W  = 36;  // Q6.30 result
	localparam int CMP_W  = 7;   // wide enough to hold a dimension of 64

	// operation codes carried on the op port
	typedef enum logic [1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_READ    = 2'd2
	} mmeq_op_t;

	// read sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} mmeq_state_t;

	// tag that travels alongside each operand pair through the datapath
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mmeq_tag_t;

endpackage

// ===== rtl/mmeq_ram.sv =====
// ----------------------------------------------------------------------------
// mmeq_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
// ----------------------------------------------------------------------------
module mmeq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/mmeq_mac.sv =====
// ----------------------------------------------------------------------------
// mmeq_mac
// Multiply-accumulate datapath: registers the Q2.30 product of each operand
// pair, accumulates over the inner dimension and saturates to Q6.30.
// ----------------------------------------------------------------------------
module mmeq_mac
	import mmeq_pkg::*;
#(
	parameter int INNER = DEF_INNER
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [VAL_W-1:0]  a_data,
	input  logic signed [VAL_W-1:0]  b_data,
	input  mmeq_tag_t                tag_s1,
	output logic                     fin,
	output logic signed [OUT_W-1:0]  sum
);

	localparam int KW    = (INNER > 1) ? $clog2(INNER) : 1;
	localparam int ACC_W = OUT_W + 1 + KW;

	logic signed [PROD_W-1:0] prod_s2;
	mmeq_tag_t                tag_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     fin_s3;
	logic signed [ACC_W-1:0]  prod_ext;
	logic                     fits;

	// product stage
	always_ff @(posedge clk) begin
		prod_s2 <= a_data * b_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	// accumulate stage, restarts on the first product of a read
	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (tag_s2.vld) begin
			acc_q <= tag_s2.first ? prod_ext : acc_q + prod_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s3 <= 1'b0;
		end else begin
			fin_s3 <= tag_s2.vld & tag_s2.last;
		end
	end

	// saturate to the output range when the upper bits are not all sign
	assign fits = (&acc_q[ACC_W-1:OUT_W-1]) | ~(|acc_q[ACC_W-1:OUT_W-1]);

	always_comb begin
		if (fits) begin
			sum = acc_q[OUT_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			sum = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sum = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	assign fin = fin_s3;

endmodule

// ===== rtl/matrix_multiply_element_query.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_element_query
// Holds matrices A and B in two RAMs, loaded one element per beat, and
// returns single elements of their product A*B as Q6.30 sums.
// ----------------------------------------------------------------------------
// writes: busy stays low, the next beat may follow at once
// in-range read: product_value with done after the RAM read, product,
//   accumulate and result registers; busy is high while one RAM read pair
//   per cycle feeds a single multiply-accumulate unit and the pipeline drains
// out-of-range read: zero result with done on the next cycle, no busy time
// reset clears the sequencer and strobes; RAM contents stay undefined
module matrix_multiply_element_query
	import mmeq_pkg::*;
#(
	parameter int ROWS_A = DEF_ROWS_A,
	parameter int INNER  = DEF_INNER,
	parameter int COLS_B = DEF_COLS_B
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              op,
	input  logic [IDX_W-1:0]        row,
	input  logic [IDX_W-1:0]        col,
	input  logic signed [VAL_W-1:0] value,
	output logic                    done,
	output logic signed [OUT_W-1:0] product_value
);

	localparam int DEPTH_A = ROWS_A * INNER;
	localparam int DEPTH_B = INNER * COLS_B;
	localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
	localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
	localparam int KW      = (INNER > 1) ? $clog2(INNER) : 1;

	mmeq_state_t state_q, state_nxt;

	logic                    accept;
	logic                    row_ok_a, col_ok_a, row_ok_b, col_ok_b;
	logic                    prow_ok, pcol_ok;
	logic                    we_a, we_b;
	logic                    rd_go, rd_zero;
	logic                    rd_en;
	logic [AW_A-1:0]         waddr_a, a_addr_q;
	logic [AW_B-1:0]         waddr_b, b_addr_q;
	logic [KW-1:0]           k_q;
	logic                    k_last;
	logic [VAL_W-1:0]        a_rdata, b_rdata;
	mmeq_tag_t               tag_s1;
	logic                    fin;
	logic signed [OUT_W-1:0] sum;
	logic                    done_q;
	logic signed [OUT_W-1:0] product_value_q;

	// beat decode and range checks
	assign accept   = start & ~busy;
	assign row_ok_a = CMP_W'(row) < CMP_W'(ROWS_A);
	assign col_ok_a = CMP_W'(col) < CMP_W'(INNER);
	assign row_ok_b = CMP_W'(row) < CMP_W'(INNER);
	assign col_ok_b = CMP_W'(col) < CMP_W'(COLS_B);
	assign prow_ok  = CMP_W'(row) < CMP_W'(ROWS_A);
	assign pcol_ok  = CMP_W'(col) < CMP_W'(COLS_B);

	assign we_a    = accept & (op == OP_WRITE_A) & row_ok_a & col_ok_a;
	assign we_b    = accept & (op == OP_WRITE_B) & row_ok_b & col_ok_b;
	assign rd_go   = accept & (op == OP_READ) & prow_ok & pcol_ok;
	assign rd_zero = accept & (op == OP_READ) & ~(prow_ok & pcol_ok);

	// row-major write addresses
	assign waddr_a = AW_A'(row) * AW_A'(INNER) + AW_A'(col);
	assign waddr_b = AW_B'(row) * AW_B'(COLS_B) + AW_B'(col);

	// sequencer: next state
	assign k_last = (k_q == KW'(INNER - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (rd_go) state_nxt = ST_ISSUE;
			ST_ISSUE: if (k_last) state_nxt = ST_DRAIN;
			ST_DRAIN: if (fin) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		busy  = 1'b1;
		rd_en = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_ISSUE: rd_en = 1'b1;
			ST_DRAIN: rd_en = 1'b0;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// read address walk: A along its row, B down its column
	always_ff @(posedge clk) begin
		if (rd_go) begin
			a_addr_q <= AW_A'(row) * AW_A'(INNER);
			b_addr_q <= AW_B'(col);
			k_q      <= '0;
		end else if (rd_en) begin
			a_addr_q <= a_addr_q + AW_A'(1);
			b_addr_q <= b_addr_q + AW_B'(COLS_B);
			k_q      <= k_q + KW'(1);
		end
	end

	// tag aligned with the registered RAM data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld   <= rd_en;
			tag_s1.first <= rd_en & (k_q == '0);
			tag_s1.last  <= rd_en & k_last;
		end
	end

	// matrix stores; writes happen only while idle, reads only while busy,
	// so the two never meet on one entry
	mmeq_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH_A)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_a),
		.wdata (value),
		.re    (rd_en),
		.raddr (a_addr_q),
		.rdata (a_rdata)
	);

	mmeq_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH_B)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr_b),
		.wdata (value),
		.re    (rd_en),
		.raddr (b_addr_q),
		.rdata (b_rdata)
	);

	// multiply-accumulate
	mmeq_mac #(
		.INNER (INNER)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.a_data ($signed(a_rdata)),
		.b_data ($signed(b_rdata)),
		.tag_s1 (tag_s1),
		.fin    (fin),
		.sum    (sum)
	);

	// result register, one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin | rd_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			product_value_q <= sum;
		end else if (rd_zero) begin
			product_value_q <= '0;
		end
	end

	assign done          = done_q;
	assign product_value = product_value_q;

endmodule

// ===== verif/matrix_multiply_element_query_tb.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_element_query_tb
// Self-checking bench for the matrix multiply element query block. Both
// matrices are first loaded in full, so every later read uses written
// entries only. A directed pass then covers the extreme sums, writes that
// replace live entries and the unused op code. A random pass follows with
// mixed loads, reads, whole-row and whole-column bursts and ignored beats.
// A scoreboard class keeps its own copy of both matrices, predicts each
// product element and compares it with the strobed result. The sender
// pauses at different rates from one phase to the next.
// ----------------------------------------------------------------------------
module matrix_multiply_element_query_tb;
	import mmeq_pkg::*;

	localparam int         ROWS_A     = DEF_ROWS_A;
	localparam int         INNER      = DEF_INNER;
	localparam int         COLS_B     = DEF_COLS_B;
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         RAND_ITEMS = 620;
	localparam int         PHASE_LEN  = 155;

	// sum predictor with its own copy of both matrices
	class product_scoreboard;
		logic signed [VAL_W-1:0] left_entries [ROWS_A][INNER];
		logic signed [VAL_W-1:0] right_entries [INNER][COLS_B];
		logic signed [OUT_W-1:0] expected_products [$];
		int errors;
		int checked;
		int loads;
		int reads;
		int ignored;

		function new();
			foreach (left_entries[i, j]) left_entries[i][j] = '0;
			foreach (right_entries[i, j]) right_entries[i][j] = '0;
			errors  = 0;
			checked = 0;
			loads   = 0;
			reads   = 0;
			ignored = 0;
		endfunction

		// exact dot product, clamped to the result range
		function logic signed [OUT_W-1:0] dot_entry(int r, int c);
			longint acc;
			longint sum_max;
			longint sum_min;
			acc     = 0;
			sum_max = (longint'(1) <<< (OUT_W - 1)) - 1;
			sum_min = -sum_max - 1;
			for (int k = 0; k < INNER; k++)
				acc += longint'(left_entries[r][k]) * longint'(right_entries[k][c]);
			if (acc > sum_max) acc = sum_max;
			if (acc < sum_min) acc = sum_min;
			return acc[OUT_W-1:0];
		endfunction

		// an input beat was accepted
		function void note_beat(logic [1:0] o, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
				logic signed [VAL_W-1:0] v);
			case (o)
				OP_WRITE_A: begin
					loads++;
					if (r < ROWS_A && c < INNER) left_entries[r][c] = v;
				end
				OP_WRITE_B: begin
					loads++;
					if (r < INNER && c < COLS_B) right_entries[r][c] = v;
				end
				OP_READ: begin
					reads++;
					if (r < ROWS_A && c < COLS_B)
						expected_products.push_back(dot_entry(r, c));
					else
						expected_products.push_back('0);
				end
				default: ignored++;
			endcase
		endfunction

		// a result beat was strobed
		function void check_result(logic signed [OUT_W-1:0] got);
			logic signed [OUT_W-1:0] want;
			if (expected_products.size() == 0) begin
				errors++;
				$display("%0t: product with none expected, expected none, actual %0d",
					$time, got);
				return;
			end
			want = expected_products.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				$display("%0t: product_value mismatch, expected %0d, actual %0d",
					$time, want, got);
			end
		endfunction
	endclass

	logic                    clk    = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start  = 1'b0;
	logic [1:0]              op     = '0;
	logic [IDX_W-1:0]        row    = '0;
	logic [IDX_W-1:0]        col    = '0;
	logic signed [VAL_W-1:0] value  = '0;
	logic                    busy;
	logic                    done;
	logic signed [OUT_W-1:0] product_value;

	product_scoreboard products = new();
	int idle_pct = 0;

	matrix_multiply_element_query #(
		.ROWS_A(ROWS_A),
		.INNER (INNER),
		.COLS_B(COLS_B)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.row          (row),
		.col          (col),
		.value        (value),
		.done         (done),
		.product_value(product_value)
	);

	always #6 clk = ~clk;

	// result beats are checked as they are strobed
	always @(posedge clk) begin
		if (arst_n && done) products.check_result(product_value);
	end

	// hard stop for a hung run
	initial begin
		#(12 * 400000);
		$display("CHECK FAILED");
		$finish;
	end

	// present one beat, hold it until accepted, sometimes after a random pause
	task automatic send_beat(input logic [1:0] o, input int r, input int c,
			input logic signed [VAL_W-1:0] v);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op    <= o;
		row   <= IDX_W'(r);
		col   <= IDX_W'(c);
		value <= v;
		do @(posedge clk); while (busy);
		products.note_beat(o, IDX_W'(r), IDX_W'(c), v);
	endtask

	// entry value biased towards the extremes
	function automatic logic signed [VAL_W-1:0] pick_entry();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(7))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return 16'hffff;
			default: return raw[VAL_W-1:0];
		endcase
	endfunction

	// preload: rows 0/1 of A and cols 0/1 of B at the extremes, rest random
	function automatic logic signed [VAL_W-1:0] preload_entry(logic [1:0] o, int r, int c);
		if (o == OP_WRITE_A && r == 0) return 16'h8000;
		if (o == OP_WRITE_A && r == 1) return 16'h7fff;
		if (o == OP_WRITE_B && c == 0) return 16'h8000;
		if (o == OP_WRITE_B && c == 1) return 16'h7fff;
		return pick_entry();
	endfunction

	function automatic int idle_for_phase(int p);
		case (p % 4)
			1:       return 55;
			3:       return 12;
			default: return 0;
		endcase
	endfunction

	initial begin
		int rand_beats;
		int pick;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		logic signed [VAL_W-1:0] v;
		logic [31:0] raw;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full load of both matrices, back to back
		idle_pct = 0;
		for (int i = 0; i < ROWS_A; i++)
			for (int k = 0; k < INNER; k++)
				send_beat(OP_WRITE_A, i, k, preload_entry(OP_WRITE_A, i, k));
		for (int k = 0; k < INNER; k++)
			for (int j = 0; j < COLS_B; j++)
				send_beat(OP_WRITE_B, k, j, preload_entry(OP_WRITE_B, k, j));

		// directed: extreme sums, corners, ignored op, live overwrites
		idle_pct = 12;
		send_beat(OP_READ, 0, 0, 16'h0000);
		send_beat(OP_READ, 0, 1, 16'hffff);
		send_beat(OP_READ, 1, 1, 16'h0000);
		send_beat(OP_READ, 1, 0, 16'h0000);
		send_beat(OP_READ, 15, 15, 16'h0000);
		send_beat(OP_READ, 0, 15, 16'h0000);
		send_beat(OP_READ, 15, 0, 16'h0000);
		send_beat(OP_UNUSED, 15, 15, 16'hffff);
		send_beat(OP_UNUSED, 0, 0, 16'h0000);
		send_beat(OP_WRITE_A, 15, 15, 16'h0000);
		send_beat(OP_WRITE_B, 15, 15, 16'hffff);
		send_beat(OP_READ, 15, 15, 16'h0000);
		send_beat(OP_WRITE_A, 15, 0, 16'h7fff);
		send_beat(OP_WRITE_B, 0, 15, 16'h8000);
		send_beat(OP_READ, 15, 15, 16'h0000);
		send_beat(OP_READ, 0, 0, 16'h0000);
		send_beat(OP_WRITE_A, 0, 0, 16'h0001);
		send_beat(OP_READ, 0, 0, 16'h0000);
		send_beat(OP_WRITE_A, 0, 0, 16'h8000);
		send_beat(OP_READ, 0, 0, 16'h0000);

		// random traffic; every entry is written, so any read is legal
		rand_beats = 0;
		while (rand_beats < RAND_ITEMS) begin
			idle_pct = idle_for_phase(rand_beats / PHASE_LEN);
			pick     = $urandom_range(99);
			raw      = $urandom;
			r        = raw[3:0];
			c        = raw[7:4];
			if (pick < 5) begin
				// burst: a whole A row or B column, then a read through it
				v = pick_entry();
				for (int k = 0; k < INNER; k++) begin
					if (raw[8])
						send_beat(OP_WRITE_A, r, k, raw[9] ? v : pick_entry());
					else
						send_beat(OP_WRITE_B, k, c, raw[9] ? v : pick_entry());
				end
				send_beat(OP_READ, r, c, pick_entry());
				rand_beats += INNER + 1;
			end else if (pick < 45) begin
				send_beat(OP_READ, r, c, pick_entry());
				rand_beats++;
			end else if (pick < 67) begin
				send_beat(OP_WRITE_A, r, c, pick_entry());
				rand_beats++;
			end else if (pick < 89) begin
				send_beat(OP_WRITE_B, r, c, pick_entry());
				rand_beats++;
			end else begin
				send_beat(OP_UNUSED, r, c, pick_entry());
				rand_beats++;
			end
		end
		start <= 1'b0;

		// drain, then allow for any stray strobe
		while (products.expected_products.size() != 0) @(posedge clk);
		repeat (INNER + 8) @(posedge clk);

		$display("covered %0d loads, %0d product reads and %0d ignored beats",
			products.loads, products.reads, products.ignored);
		$display("%0d products compared, %0d errors", products.checked, products.errors);
		if (products.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
